### sv/gwvp_pkg.sv
// ----------------------------------------------------------------------------
// gwvp_pkg
// Shared types, constants and helpers of the G-code word value parser.
// ----------------------------------------------------------------------------
package gwvp_pkg;

  localparam int LETTER_COUNT  = 26;
  localparam int FRACTION_BITS = 16;
  localparam int MAX_DIGITS    = 9;

  localparam int ACC_W    = 48;
  localparam int EXP_W    = 4;
  localparam int IDX_W    = 5;
  localparam int DIV_W    = 30;                 // widest power of ten
  localparam int PROD_W   = DIV_W + 4;          // digit times power of ten
  localparam int SHIFT_W  = PROD_W + FRACTION_BITS;
  localparam int SUM_W    = ((SHIFT_W > ACC_W - 1) ? SHIFT_W : ACC_W - 1) + 2;
  localparam int DIV_STEPS = ACC_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_CHAR  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [DIV_W-1:0] POW_TEN [10] = '{
    30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
    30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
  };

  typedef enum logic [2:0] {
    CC_LETTER,
    CC_DIGIT,
    CC_DOT,
    CC_MINUS,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic step_char;
    logic mul;
    logic add;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic query;
  } gwvp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        div_last;
  } gwvp_status_t;

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t r;
    if (c >= CH_A && c <= CH_Z) begin
      r = CC_LETTER;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r = CC_DIGIT;
    end else if (c == CH_DOT) begin
      r = CC_DOT;
    end else if (c == CH_MINUS) begin
      r = CC_MINUS;
    end else begin
      r = CC_OTHER;
    end
    return r;
  endfunction

endpackage

### sv/gcode_word_value_parser.sv
// Sequence: a clear passes S_CLEAR, a non-digit character S_CHAR, a digit
// S_CHAR and S_ADD, a dot S_CHAR, 48 divider steps in S_DIV (one quotient
// bit a cycle) and S_DIVFIN. A query registers its result in S_QUERY.
// Items are accepted in idle; a query also needs a free or emptying result.
// Reset empties the letter table and zeroes the accumulator and exponent.
// ----------------------------------------------------------------------------
// gcode_word_value_parser
// Parses one G-code line, fed last character first, into a table of letter
// values in signed Q32.16 fixed point and answers letter queries.
// ----------------------------------------------------------------------------
module gcode_word_value_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic [7:0]                        char_code,
  input  logic [gwvp_pkg::IDX_W-1:0]        letter_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              has_value,
  output logic signed [gwvp_pkg::ACC_W-1:0] letter_value
);

  gwvp_pkg::gwvp_cmd_t    cmd;
  gwvp_pkg::gwvp_status_t status;

  gwvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gwvp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .letter_index (letter_index),
    .cmd          (cmd),
    .status       (status),
    .has_value    (has_value),
    .letter_value (letter_value)
  );

endmodule

### sv/gwvp_ctrl.sv
// ----------------------------------------------------------------------------
// gwvp_ctrl
// Sequencer of the parser: accepts items, issues datapath commands and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module gwvp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  gwvp_pkg::gwvp_status_t status,
  output gwvp_pkg::gwvp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_CHAR,
    S_ADD,
    S_DIV,
    S_DIVFIN,
    S_QUERY
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // A query needs the result register, which must be free or emptying now.
  assign in_ready = (state == S_IDLE) &&
                    ((func != gwvp_pkg::FUNC_QUERY) || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          case (func)
            gwvp_pkg::FUNC_CLEAR: state_next = S_CLEAR;
            gwvp_pkg::FUNC_CHAR:  state_next = S_CHAR;
            gwvp_pkg::FUNC_QUERY: state_next = S_QUERY;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      S_CHAR: begin
        case (status.cls)
          gwvp_pkg::CC_DIGIT: begin
            cmd.mul    = 1'b1;
            state_next = S_ADD;
          end
          gwvp_pkg::CC_DOT: begin
            cmd.div_init = 1'b1;
            state_next   = S_DIV;
          end
          default: begin
            cmd.step_char = 1'b1;
            state_next    = S_IDLE;
          end
        endcase
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIVFIN;
        end
      end
      S_DIVFIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_IDLE;
      end
      S_QUERY: begin
        cmd.query  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_QUERY) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/gwvp_dp.sv
// ----------------------------------------------------------------------------
// gwvp_dp
// Datapath of the parser: accumulator, digit exponent, letter table,
// digit multiplier, restoring divider and the result register.
// ----------------------------------------------------------------------------
module gwvp_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   char_code,
  input  logic [gwvp_pkg::IDX_W-1:0]   letter_index,
  input  gwvp_pkg::gwvp_cmd_t          cmd,
  output gwvp_pkg::gwvp_status_t       status,
  output logic                         has_value,
  output logic signed [gwvp_pkg::ACC_W-1:0] letter_value
);

  localparam logic signed [gwvp_pkg::SUM_W-1:0] SUM_MAX =
    {{(gwvp_pkg::SUM_W - gwvp_pkg::ACC_W + 1){1'b0}}, {(gwvp_pkg::ACC_W - 1){1'b1}}};
  localparam logic signed [gwvp_pkg::SUM_W-1:0] SUM_MIN =
    {{(gwvp_pkg::SUM_W - gwvp_pkg::ACC_W + 1){1'b1}}, {(gwvp_pkg::ACC_W - 1){1'b0}}};
  localparam logic signed [gwvp_pkg::ACC_W-1:0] ACC_MAX =
    {1'b0, {(gwvp_pkg::ACC_W - 1){1'b1}}};
  localparam logic signed [gwvp_pkg::ACC_W-1:0] ACC_MIN =
    {1'b1, {(gwvp_pkg::ACC_W - 1){1'b0}}};

  logic [7:0]                       char_q;
  logic [gwvp_pkg::IDX_W-1:0]       idx_q;
  logic signed [gwvp_pkg::ACC_W-1:0] acc;
  logic [gwvp_pkg::EXP_W-1:0]       expo;
  logic [gwvp_pkg::ACC_W-1:0]       word_values [gwvp_pkg::LETTER_COUNT];
  logic [gwvp_pkg::LETTER_COUNT-1:0] word_present;
  logic [gwvp_pkg::PROD_W-1:0]      prod;

  logic [gwvp_pkg::DIV_W-1:0]       divisor;
  logic [gwvp_pkg::DIV_W-1:0]       rem;
  logic [gwvp_pkg::ACC_W-1:0]       quo;
  logic                             div_neg;
  logic [gwvp_pkg::CNT_W-1:0]       div_cnt;

  logic [gwvp_pkg::EXP_W-1:0]       n_eff;
  logic [3:0]                       digit;
  logic [gwvp_pkg::IDX_W-1:0]       letter_k;
  logic [gwvp_pkg::SHIFT_W-1:0]     add_val;
  logic signed [gwvp_pkg::SUM_W-1:0] sum;
  logic signed [gwvp_pkg::ACC_W-1:0] sum_sat;
  logic [gwvp_pkg::DIV_W:0]         trial;
  logic                             ge;
  logic [gwvp_pkg::ACC_W-1:0]       mag;
  logic signed [gwvp_pkg::ACC_W-1:0] neg_acc;

  assign status.cls      = gwvp_pkg::char_class(char_q);
  assign status.div_last = (div_cnt == gwvp_pkg::CNT_W'(gwvp_pkg::DIV_STEPS - 1));

  assign n_eff    = (expo > gwvp_pkg::EXP_W'(gwvp_pkg::MAX_DIGITS)) ?
                    gwvp_pkg::EXP_W'(gwvp_pkg::MAX_DIGITS) : expo;
  assign digit    = 4'(char_q - gwvp_pkg::CH_ZERO);
  assign letter_k = gwvp_pkg::IDX_W'(char_q - gwvp_pkg::CH_A);

  assign add_val = {prod, {gwvp_pkg::FRACTION_BITS{1'b0}}};
  assign sum     = $signed({{(gwvp_pkg::SUM_W - gwvp_pkg::ACC_W){acc[gwvp_pkg::ACC_W-1]}}, acc})
                 + $signed({{(gwvp_pkg::SUM_W - gwvp_pkg::SHIFT_W){1'b0}}, add_val});
  assign sum_sat = (sum > SUM_MAX) ? ACC_MAX :
                   (sum < SUM_MIN) ? ACC_MIN : sum[gwvp_pkg::ACC_W-1:0];

  // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
  assign trial = {rem, quo[gwvp_pkg::ACC_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  assign mag     = acc[gwvp_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
  assign neg_acc = ~acc + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_q <= char_code;
      idx_q  <= letter_index;
    end

    if (cmd.mul) begin
      prod <= gwvp_pkg::PROD_W'(digit) * gwvp_pkg::PROD_W'(gwvp_pkg::POW_TEN[n_eff]);
    end

    if (cmd.div_init) begin
      divisor <= gwvp_pkg::POW_TEN[n_eff];
      rem     <= '0;
      quo     <= mag;
      div_neg <= acc[gwvp_pkg::ACC_W-1];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? gwvp_pkg::DIV_W'(trial - {1'b0, divisor}) :
                      trial[gwvp_pkg::DIV_W-1:0];
      quo     <= {quo[gwvp_pkg::ACC_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end

    if (cmd.step_char && status.cls == gwvp_pkg::CC_LETTER) begin
      word_values[letter_k] <= acc;
    end

    if (cmd.query) begin
      if (idx_q < gwvp_pkg::IDX_W'(gwvp_pkg::LETTER_COUNT) && word_present[idx_q]) begin
        has_value    <= 1'b1;
        letter_value <= word_values[idx_q];
      end else begin
        has_value    <= 1'b0;
        letter_value <= '0;
      end
    end

    if (rst || cmd.clear) begin
      acc          <= '0;
      expo         <= '0;
      word_present <= '0;
    end else if (cmd.step_char) begin
      case (status.cls)
        gwvp_pkg::CC_LETTER: begin
          word_present[letter_k] <= 1'b1;
          acc                    <= '0;
          expo                   <= '0;
        end
        gwvp_pkg::CC_MINUS: begin
          acc <= (acc == ACC_MIN) ? ACC_MAX : neg_acc;
        end
        default: begin
          acc  <= '0;
          expo <= '0;
        end
      endcase
    end else if (cmd.mul) begin
      expo <= (n_eff < gwvp_pkg::EXP_W'(gwvp_pkg::MAX_DIGITS)) ? n_eff + 1'b1 : n_eff;
    end else if (cmd.add) begin
      acc <= sum_sat;
    end else if (cmd.div_init) begin
      expo <= '0;
    end else if (cmd.div_fin) begin
      acc <= div_neg ? $signed(~quo + 1'b1) : $signed(quo);
    end
  end

endmodule

### sv/gwvp_checker.sv
// ----------------------------------------------------------------------------
// gwvp_port_checks
// Port-level checks of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gwvp_port_checks (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        func,
  input logic [7:0]                        char_code,
  input logic [gwvp_pkg::IDX_W-1:0]        letter_index,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              has_value,
  input logic signed [gwvp_pkg::ACC_W-1:0] letter_value
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(has_value) && $stable(letter_value))
    else $error("result changed while stalled");

  // An unset letter always reads as zero.
  a_unset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_value |-> letter_value == '0)
    else $error("unset letter with nonzero value");

  // Each query transfer is followed by a valid result.
  a_query_lat: assert property (@(posedge clk) disable iff (rst)
    in_xfer && func == gwvp_pkg::FUNC_QUERY |-> ##2 out_valid)
    else $error("query result missing");

  // A query straight after a clear finds the letter unset.
  a_clear_query: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && func == gwvp_pkg::FUNC_CLEAR) ##2 (in_xfer && func == gwvp_pkg::FUNC_QUERY)
    |-> ##2 (out_valid && !has_value))
    else $error("letter set after clear");

  // No result is pending right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gcode_word_value_parser gwvp_port_checks u_gwvp_port_checks (.*);
